>>> src/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and TELNET code constants for the command stripper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcs_pkg;

	localparam logic [7:0] TN_IAC      = 8'd255;
	localparam logic [7:0] TN_SE       = 8'd240;
	localparam logic [7:0] TN_SB       = 8'd250;
	localparam logic [7:0] TN_WILL     = 8'd251;
	localparam logic [7:0] TN_WONT     = 8'd252;
	localparam logic [7:0] TN_DO       = 8'd253;
	localparam logic [7:0] TN_DONT     = 8'd254;
	localparam logic [7:0] TN_OPT_ECHO = 8'd1;

	typedef enum logic [2:0] {
		PH_NORMAL = 3'd0,
		PH_IAC    = 3'd1,
		PH_OPTION = 3'd2,
		PH_SB     = 3'd3,
		PH_SBDATA = 3'd4,
		PH_SBIAC  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		VERB_OTHER = 2'd0,
		VERB_WILL  = 2'd1,
		VERB_WONT  = 2'd2
	} verb_t;

endpackage

`default_nettype wire

>>> src/telnet_command_stripper_top.sv
// ----------------------------------------------------------------------------
// telnet_command_stripper_top
// Per-direction TELNET parser: strips IAC commands and subnegotiations,
// tracks remote ECHO state, tags data words with a suppress flag.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  in      | in_valid, in_stall, direction, data_byte | in
//  out     | out_valid, out_stall, out_direction,     | out
//          | out_byte, suppress                       |
//  cfg     | cfg_wen, cfg_wdata (raw_mode)            | in
//
// One word per cycle sustained while the output is not stalled. A word is
// registered at the input (s1), parsed against the per-direction state, and
// then moves into the output register. Reset clears both parsers, both echo
// flags and selects raw mode. in_stall rises only while the output register is
// full and stalled; outside raw mode, command words leave no output word.
`timescale 1ns / 1ps
`default_nettype none

module telnet_command_stripper_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wen,
	input  wire logic       cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       direction,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            out_direction,
	output logic [7:0]      out_byte,
	output logic            suppress
);

	logic              raw_mode_q;
	logic              valid_s1;
	logic              dir_s1;
	logic [7:0]        byte_s1;
	tcs_pkg::phase_t   phase_q [2];
	tcs_pkg::verb_t    verb_q  [2];
	logic [1:0]        echo_q;

	logic              adv;
	logic              emit;
	logic              dir_o;
	tcs_pkg::phase_t   cur_phase;
	tcs_pkg::phase_t   nxt_phase;
	tcs_pkg::verb_t    nxt_verb;
	logic              echo_wr;
	logic              echo_val;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign dir_o    = ~dir_s1;
	assign cur_phase = phase_q[dir_s1];

	always_comb begin
		emit      = 1'b0;
		nxt_phase = cur_phase;
		nxt_verb  = verb_q[dir_s1];
		echo_wr   = 1'b0;
		echo_val  = 1'b0;
		if (raw_mode_q) begin
			emit = 1'b1;
		end else begin
			unique case (cur_phase)
				tcs_pkg::PH_IAC: begin
					if (byte_s1 == tcs_pkg::TN_IAC) begin
						emit      = 1'b1;
						nxt_phase = tcs_pkg::PH_NORMAL;
					end else if (byte_s1 == tcs_pkg::TN_WILL || byte_s1 == tcs_pkg::TN_WONT ||
							byte_s1 == tcs_pkg::TN_DO || byte_s1 == tcs_pkg::TN_DONT) begin
						if (byte_s1 == tcs_pkg::TN_WILL)
							nxt_verb = tcs_pkg::VERB_WILL;
						else if (byte_s1 == tcs_pkg::TN_WONT)
							nxt_verb = tcs_pkg::VERB_WONT;
						else
							nxt_verb = tcs_pkg::VERB_OTHER;
						nxt_phase = tcs_pkg::PH_OPTION;
					end else if (byte_s1 == tcs_pkg::TN_SB) begin
						nxt_phase = tcs_pkg::PH_SB;
					end else begin
						nxt_phase = tcs_pkg::PH_NORMAL;
					end
				end
				tcs_pkg::PH_OPTION: begin
					// WILL/WONT ECHO from one side sets the echo flag of the other
					if (byte_s1 == tcs_pkg::TN_OPT_ECHO) begin
						if (verb_q[dir_s1] == tcs_pkg::VERB_WILL) begin
							echo_wr  = 1'b1;
							echo_val = 1'b1;
						end else if (verb_q[dir_s1] == tcs_pkg::VERB_WONT) begin
							echo_wr  = 1'b1;
							echo_val = 1'b0;
						end
					end
					nxt_phase = tcs_pkg::PH_NORMAL;
				end
				tcs_pkg::PH_SB: begin
					nxt_phase = tcs_pkg::PH_SBDATA;
				end
				tcs_pkg::PH_SBDATA: begin
					nxt_phase = (byte_s1 == tcs_pkg::TN_IAC) ? tcs_pkg::PH_SBIAC
						: tcs_pkg::PH_SBDATA;
				end
				tcs_pkg::PH_SBIAC: begin
					nxt_phase = (byte_s1 == tcs_pkg::TN_SE) ? tcs_pkg::PH_NORMAL
						: tcs_pkg::PH_SBDATA;
				end
				default: begin
					if (byte_s1 == tcs_pkg::TN_IAC)
						nxt_phase = tcs_pkg::PH_IAC;
					else
						emit = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q <= 1'b1;
		end else if (cfg_wen) begin
			raw_mode_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			dir_s1  <= direction;
			byte_s1 <= data_byte;
		end
	end

	// parser state, updated when the s1 word is consumed outside raw mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q[0] <= tcs_pkg::PH_NORMAL;
			phase_q[1] <= tcs_pkg::PH_NORMAL;
			verb_q[0]  <= tcs_pkg::VERB_OTHER;
			verb_q[1]  <= tcs_pkg::VERB_OTHER;
			echo_q     <= 2'b00;
		end else if (valid_s1 && adv && !raw_mode_q) begin
			phase_q[dir_s1] <= nxt_phase;
			verb_q[dir_s1]  <= nxt_verb;
			if (echo_wr)
				echo_q[dir_o] <= echo_val;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && emit) begin
			out_direction <= dir_s1;
			out_byte      <= byte_s1;
			suppress      <= echo_q[dir_s1] && !raw_mode_q;
		end
	end

endmodule

`default_nettype wire

>>> src/tcs_checker.sv
// ----------------------------------------------------------------------------
// tcs_checker
// Port-level assertions for the command stripper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       out_direction,
	input wire logic [7:0] out_byte,
	input wire logic       suppress
);

	// held output word keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) &&
			$stable(out_direction) && $stable(suppress))
		else $error("output word changed while stalled");

	// input backpressure only comes from a full, stalled output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// a fresh output word needs an input word accepted earlier through s1
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output word without matching input word");

	// nothing pending right after reset release
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("output not empty after reset");

endmodule

bind telnet_command_stripper_top tcs_checker u_tcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.out_direction (out_direction),
	.out_byte      (out_byte),
	.suppress      (suppress)
);

`default_nettype wire
